// ===== rtl/mahd_pkg.sv =====
// Shared types, constants and lookup tables of the MPEG audio header decoder.
package mahd_pkg;

  // Header field codes.
  localparam logic [10:0] SYNC_PATTERN = 11'h7FF;
  localparam logic [1:0]  VER_MPEG25   = 2'd0;
  localparam logic [1:0]  VER_RESERVED = 2'd1;
  localparam logic [1:0]  VER_MPEG2    = 2'd2;
  localparam logic [1:0]  VER_MPEG1    = 2'd3;
  localparam logic [1:0]  LAY_RESERVED = 2'd0;
  localparam logic [1:0]  LAY_III      = 2'd1;
  localparam logic [1:0]  LAY_II       = 2'd2;
  localparam logic [1:0]  LAY_I        = 2'd3;
  localparam logic [3:0]  BRI_FREE     = 4'd0;
  localparam logic [3:0]  BRI_BAD      = 4'hF;
  localparam logic [1:0]  SRI_RESERVED = 2'd3;
  localparam logic [1:0]  MODE_MONO    = 2'd3;

  // Result constants.
  localparam logic [2:0]  HDR_BYTES_CRC   = 3'd6;
  localparam logic [2:0]  HDR_BYTES_PLAIN = 3'd4;
  localparam logic [1:0]  CHAN_MONO       = 2'd1;
  localparam logic [1:0]  CHAN_STEREO     = 2'd2;
  localparam logic [1:0]  LAYNUM_NONE     = 2'd0;
  localparam logic [1:0]  LAYNUM_1        = 2'd1;
  localparam logic [1:0]  LAYNUM_2        = 2'd2;
  localparam logic [1:0]  LAYNUM_3        = 2'd3;
  localparam logic [10:0] SPF_384         = 11'd384;
  localparam logic [10:0] SPF_576         = 11'd576;
  localparam logic [10:0] SPF_1152        = 11'd1152;

  // Field widths.
  localparam int BR_W    = 19;
  localparam int FS_W    = 16;
  localparam int SPF_W   = 11;
  localparam int BYTES_W = 11;
  localparam int SCL_W   = 16;             // bitrate over bits per slot
  localparam int DIVD_W  = SPF_W + SCL_W;  // samples times scaled bitrate

  // Slot divider: quotient never reaches 4096, three quotient bits a cycle.
  localparam int QUO_W         = 12;
  localparam int BITS_PER_STEP = 3;
  localparam int NUM_STEPS     = QUO_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(NUM_STEPS);

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Bitrate tables indexed by bitrate index.
  localparam logic [BR_W-1:0] BR_V1_L1 [0:15] = '{
    19'd0, 19'd32000, 19'd64000, 19'd96000, 19'd128000, 19'd160000, 19'd192000,
    19'd224000, 19'd256000, 19'd288000, 19'd320000, 19'd352000, 19'd384000,
    19'd416000, 19'd448000, 19'd0};
  localparam logic [BR_W-1:0] BR_V1_L2 [0:15] = '{
    19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
    19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000, 19'd256000,
    19'd320000, 19'd384000, 19'd0};
  localparam logic [BR_W-1:0] BR_V1_L3 [0:15] = '{
    19'd0, 19'd32000, 19'd40000, 19'd48000, 19'd56000, 19'd64000, 19'd80000,
    19'd96000, 19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000,
    19'd256000, 19'd320000, 19'd0};
  localparam logic [BR_W-1:0] BR_V2_L1 [0:15] = '{
    19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
    19'd112000, 19'd128000, 19'd144000, 19'd160000, 19'd176000, 19'd192000,
    19'd224000, 19'd256000, 19'd0};
  localparam logic [BR_W-1:0] BR_V2_L23 [0:15] = '{
    19'd0, 19'd8000, 19'd16000, 19'd24000, 19'd32000, 19'd40000, 19'd48000,
    19'd56000, 19'd64000, 19'd80000, 19'd96000, 19'd112000, 19'd128000,
    19'd144000, 19'd160000, 19'd0};

  // Sample-rate tables indexed by sample-rate index.
  localparam logic [FS_W-1:0] FS_V1  [0:3] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
  localparam logic [FS_W-1:0] FS_V2  [0:3] = '{16'd22050, 16'd24000, 16'd16000, 16'd0};
  localparam logic [FS_W-1:0] FS_V25 [0:3] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};

  // Decoded item that travels from the front through the queue to the back.
  typedef struct packed {
    logic              sync_ok;
    logic [1:0]        version_code;
    logic [1:0]        layer_number;
    logic [BR_W-1:0]   bitrate_bps;
    logic [FS_W-1:0]   sample_rate_hz;
    logic [SPF_W-1:0]  frame_samples;
    logic [2:0]        header_bytes;
    logic [1:0]        channel_count;
    logic              crc_present;
    logic              copyright_flag;
    logic              original_flag;
    logic              pad;
    logic              slot_wide;  // Layer I: four-byte slots
    logic              len_ok;     // frame length is defined
    logic [DIVD_W-1:0] dividend;
  } item_t;

  // Working registers of the slot divider.
  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [DIVD_W-1:0] dsh;
    logic [QUO_W-1:0]  quo;
  } div_state_t;

  // Bitrate lookup by version, layer code and bitrate index.
  function automatic logic [BR_W-1:0] bitrate_lookup(input logic [1:0] ver,
                                                     input logic [1:0] lay,
                                                     input logic [3:0] bri);
    logic [BR_W-1:0] br;
    br = '0;
    unique case (ver)
      VER_MPEG1: begin
        unique case (lay)
          LAY_I:   br = BR_V1_L1[bri];
          LAY_II:  br = BR_V1_L2[bri];
          LAY_III: br = BR_V1_L3[bri];
          default: br = '0;
        endcase
      end
      VER_MPEG2, VER_MPEG25: begin
        unique case (lay)
          LAY_I:           br = BR_V2_L1[bri];
          LAY_II, LAY_III: br = BR_V2_L23[bri];
          default:         br = '0;
        endcase
      end
      default: br = '0;
    endcase
    return br;
  endfunction

  // Sample-rate lookup by version and sample-rate index.
  function automatic logic [FS_W-1:0] rate_lookup(input logic [1:0] ver,
                                                  input logic [1:0] sri);
    logic [FS_W-1:0] fs;
    fs = '0;
    unique case (ver)
      VER_MPEG1:  fs = FS_V1[sri];
      VER_MPEG2:  fs = FS_V2[sri];
      VER_MPEG25: fs = FS_V25[sri];
      default:    fs = '0;
    endcase
    return fs;
  endfunction

  // Samples per frame by version and layer code.
  function automatic logic [SPF_W-1:0] spf_lookup(input logic [1:0] ver,
                                                  input logic [1:0] lay);
    logic [SPF_W-1:0] spf;
    spf = '0;
    if (ver != VER_RESERVED) begin
      unique case (lay)
        LAY_I:   spf = SPF_384;
        LAY_II:  spf = SPF_1152;
        LAY_III: spf = (ver == VER_MPEG1) ? SPF_1152 : SPF_576;
        default: spf = '0;
      endcase
    end
    return spf;
  endfunction

  // One cycle of the restoring divider: three compare-and-subtract steps.
  function automatic div_state_t div_step(input div_state_t s);
    div_state_t r;
    r = s;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      if (r.rem >= r.dsh) begin
        r.rem = r.rem - r.dsh;
        r.quo = {r.quo[QUO_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QUO_W-2:0], 1'b0};
      end
      r.dsh = r.dsh >> 1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/mahd_front.sv =====
// Front end: accepts header words, unpacks and checks them, and forms the slot dividend.
module mahd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          header_word,
  output logic                 push_valid,
  input  logic                 push_ready,
  output mahd_pkg::item_t      push_item
);

  logic [10:0] sync;
  logic [1:0]  ver;
  logic [1:0]  lay;
  logic        prot;
  logic [3:0]  bri;
  logic [1:0]  sri;
  logic [1:0]  mode;
  mahd_pkg::item_t dec;
  logic [mahd_pkg::SCL_W-1:0] scaled_d;

  logic            s1_valid;
  mahd_pkg::item_t s1_item;
  logic [mahd_pkg::SCL_W-1:0] s1_scaled;
  logic            accept;
  logic [mahd_pkg::DIVD_W-1:0] product;

  // Unpack the header fields.
  assign sync = header_word[31:21];
  assign ver  = header_word[20:19];
  assign lay  = header_word[18:17];
  assign prot = header_word[16];
  assign bri  = header_word[15:12];
  assign sri  = header_word[11:10];
  assign mode = header_word[7:6];

  // Classify the header and look up its rates.
  always_comb begin
    dec = '0;
    dec.sync_ok = (sync == mahd_pkg::SYNC_PATTERN) && (lay != mahd_pkg::LAY_RESERVED) &&
                  (ver != mahd_pkg::VER_RESERVED) && (bri != mahd_pkg::BRI_BAD) &&
                  (bri != mahd_pkg::BRI_FREE) && (sri != mahd_pkg::SRI_RESERVED) &&
                  !(((ver == mahd_pkg::VER_MPEG2) || (ver == mahd_pkg::VER_MPEG25)) &&
                    (lay != mahd_pkg::LAY_III));
    dec.version_code = ver;
    unique case (lay)
      mahd_pkg::LAY_I:   dec.layer_number = mahd_pkg::LAYNUM_1;
      mahd_pkg::LAY_II:  dec.layer_number = mahd_pkg::LAYNUM_2;
      mahd_pkg::LAY_III: dec.layer_number = mahd_pkg::LAYNUM_3;
      default:           dec.layer_number = mahd_pkg::LAYNUM_NONE;
    endcase
    dec.bitrate_bps       = mahd_pkg::bitrate_lookup(ver, lay, bri);
    dec.sample_rate_hz    = mahd_pkg::rate_lookup(ver, sri);
    dec.frame_samples     = mahd_pkg::spf_lookup(ver, lay);
    dec.header_bytes      = prot ? mahd_pkg::HDR_BYTES_PLAIN : mahd_pkg::HDR_BYTES_CRC;
    dec.channel_count     = (mode == mahd_pkg::MODE_MONO) ? mahd_pkg::CHAN_MONO
                                                          : mahd_pkg::CHAN_STEREO;
    dec.crc_present       = !prot;
    dec.copyright_flag    = header_word[3];
    dec.original_flag     = header_word[2];
    dec.pad               = header_word[9];
    dec.slot_wide         = (lay == mahd_pkg::LAY_I);
    dec.len_ok            = (dec.sample_rate_hz != '0) && (lay != mahd_pkg::LAY_RESERVED);
    dec.dividend          = '0;
  end

  // Bitrate in slots: eight bits per slot, or 32 for Layer I.
  assign scaled_d = dec.slot_wide ? mahd_pkg::SCL_W'(dec.bitrate_bps >> 5)
                                  : mahd_pkg::SCL_W'(dec.bitrate_bps >> 3);

  // Decode stage register; it holds while the queue is full.
  assign accept   = in_valid && !in_stall;
  assign in_stall = s1_valid && !push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item   <= dec;
      s1_scaled <= scaled_d;
    end
  end

  // Samples per frame times slots per second, registered by the queue.
  assign product = mahd_pkg::DIVD_W'(s1_item.frame_samples) *
                   mahd_pkg::DIVD_W'(s1_scaled);

  always_comb begin
    push_item          = s1_item;
    push_item.dividend = product;
  end

  assign push_valid = s1_valid;

endmodule

// ===== rtl/mahd_queue.sv =====
// Short queue of decoded items between the front end and the back end.
module mahd_queue #(
  parameter int DEPTH = mahd_pkg::QUEUE_DEPTH  // two or more entries
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mahd_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output mahd_pkg::item_t pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mahd_pkg::item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push_fire;
  logic pop_fire;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count stays within the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  // With no traffic the fill count holds.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !push_fire && !pop_fire |=> $stable(count))
    else $error("queue count changed without traffic");

endmodule

// ===== rtl/mahd_back.sv =====
// Back end: slot divider, frame length and the output register.
module mahd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  mahd_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          sync_ok,
  output logic [1:0]                    version_code,
  output logic [1:0]                    layer_number,
  output logic [mahd_pkg::BR_W-1:0]     bitrate_bps,
  output logic [mahd_pkg::FS_W-1:0]     sample_rate_hz,
  output logic [mahd_pkg::SPF_W-1:0]    frame_samples,
  output logic [mahd_pkg::BYTES_W-1:0]  frame_bytes,
  output logic [2:0]                    header_bytes,
  output logic [1:0]                    channel_count,
  output logic                          crc_present,
  output logic                          copyright_flag,
  output logic                          original_flag
);

  localparam logic [mahd_pkg::STEP_W-1:0] LAST_STEP =
    mahd_pkg::STEP_W'(mahd_pkg::NUM_STEPS - 1);

  logic                         busy;
  logic [mahd_pkg::STEP_W-1:0]  step;
  mahd_pkg::div_state_t         div;
  mahd_pkg::div_state_t         div_init;
  mahd_pkg::div_state_t         div_next;
  mahd_pkg::item_t              item;
  logic                         out_free;
  logic                         advance;
  logic                         finish;
  logic [mahd_pkg::QUO_W:0]     slots_pad;
  logic [mahd_pkg::BYTES_W-1:0] bytes_d;

  // Start a new division only when the divider is free.
  assign q_pop    = !busy && q_valid;
  assign out_free = !out_valid || !out_stall;
  assign advance  = busy && ((step != LAST_STEP) || out_free);
  assign finish   = advance && (step == LAST_STEP);

  // Divisor starts aligned to the top quotient bit.
  always_comb begin
    div_init.rem = q_item.dividend;
    div_init.dsh = mahd_pkg::DIVD_W'(q_item.sample_rate_hz) << (mahd_pkg::QUO_W - 1);
    div_init.quo = '0;
  end

  assign div_next = mahd_pkg::div_step(busy ? div : div_init);

  // Frame bytes from slots plus padding.
  assign slots_pad = {1'b0, div_next.quo} + {{mahd_pkg::QUO_W{1'b0}}, item.pad};
  always_comb begin
    if (!item.len_ok) begin
      bytes_d = '0;
    end else if (item.slot_wide) begin
      bytes_d = mahd_pkg::BYTES_W'({slots_pad, 2'b00});
    end else begin
      bytes_d = mahd_pkg::BYTES_W'(slots_pad);
    end
  end

  // Divider control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      step <= mahd_pkg::STEP_W'(1);
    end else if (finish) begin
      busy <= 1'b0;
    end else if (advance) begin
      step <= step + 1'b1;
    end
  end

  // Divider datapath and held item.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      div  <= div_next;
      item <= q_item;
    end else if (advance) begin
      div <= div_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sync_ok           <= item.sync_ok;
      version_code      <= item.version_code;
      layer_number      <= item.layer_number;
      bitrate_bps       <= item.bitrate_bps;
      sample_rate_hz    <= item.sample_rate_hz;
      frame_samples     <= item.frame_samples;
      frame_bytes       <= bytes_d;
      header_bytes      <= item.header_bytes;
      channel_count     <= item.channel_count;
      crc_present       <= item.crc_present;
      copyright_flag    <= item.copyright_flag;
      original_flag     <= item.original_flag;
    end
  end

  // A finished division always lands in the output register.
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    busy && (step == LAST_STEP) && out_free |=> out_valid)
    else $error("finished item did not reach the output");

  // A reserved sample rate never yields a frame length.
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sample_rate_hz == '0) |-> (frame_bytes == '0))
    else $error("frame length given without a sample rate");

  // The divider only starts from a queued item.
  a_start_src: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(q_valid))
    else $error("divider started without a queued item");

endmodule

// ===== rtl/mpeg_audio_header_decode_top.sv =====
// Top level of the MPEG audio frame header decoder.
// Each item is one 32-bit header word, first stream byte in bits 31 to 24; each yields one
// result with the header's validity, version, layer, bitrate, sample rate, samples per frame,
// frame length in bytes and header flags. The front end decodes each word into a stage register
// and the queue holds decoded items, so the input keeps taking words while the back end works,
// until the queue fills. The back end's slot divider resolves three quotient bits a cycle and
// takes the next item from the queue only once it has finished the current one. An accepted
// word passes the decode register, the queue, the divider and then the output register.
// The result sits in an output register; while it is stalled the divider works through the
// next item up to its last step and finishes it in the cycle the output register is taken.
module mpeg_audio_header_decode_top #(
  parameter int QUEUE_DEPTH = mahd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   header_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          sync_ok,
  output logic [1:0]                    version_code,
  output logic [1:0]                    layer_number,
  output logic [mahd_pkg::BR_W-1:0]     bitrate_bps,
  output logic [mahd_pkg::FS_W-1:0]     sample_rate_hz,
  output logic [mahd_pkg::SPF_W-1:0]    frame_samples,
  output logic [mahd_pkg::BYTES_W-1:0]  frame_bytes,
  output logic [2:0]                    header_bytes,
  output logic [1:0]                    channel_count,
  output logic                          crc_present,
  output logic                          copyright_flag,
  output logic                          original_flag
);

  logic            push_valid;
  logic            push_ready;
  mahd_pkg::item_t push_item;
  logic            q_valid;
  logic            q_pop;
  mahd_pkg::item_t q_item;

  // Decode stage.
  mahd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .header_word(header_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue between the two halves.
  mahd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  // Divider and output register.
  mahd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sync_ok          (sync_ok),
    .version_code     (version_code),
    .layer_number     (layer_number),
    .bitrate_bps      (bitrate_bps),
    .sample_rate_hz   (sample_rate_hz),
    .frame_samples    (frame_samples),
    .frame_bytes      (frame_bytes),
    .header_bytes     (header_bytes),
    .channel_count    (channel_count),
    .crc_present      (crc_present),
    .copyright_flag   (copyright_flag),
    .original_flag    (original_flag)
  );

endmodule
